// ===== sv/ptsb_pkg.sv =====
// ----------------------------------------------------------------------------
// ptsb_pkg: shared types and constants of the point to scan binner
// Operation codes, CORDIC angle table and controller/datapath command types.
// ----------------------------------------------------------------------------
package ptsb_pkg;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   localparam int CORDIC_STEPS = 24;
   localparam int FRAC_SHIFT   = 24;
   localparam int SQRT_STEPS   = 16;
   localparam int ACC_BITS     = 34;
   localparam int STEP_BITS    = 5;

   localparam logic [14:0] MAX_RANGE_RESET = 15'd3000;
   localparam logic [15:0] FILL_MARGIN     = 16'd1000;
   localparam logic [31:0] HALF_PI_UNITS   = 32'h4000_0000;
   localparam logic [31:0] PI_UNITS        = 32'h8000_0000;

   // atan(2^-i) in units of pi/2^31
   function automatic logic [31:0] atan_units(input logic [STEP_BITS-1:0] i);
      logic [31:0] v;
      case (i)
         5'd0:    v = 32'd536870912;
         5'd1:    v = 32'd316933406;
         5'd2:    v = 32'd167458907;
         5'd3:    v = 32'd85004756;
         5'd4:    v = 32'd42667331;
         5'd5:    v = 32'd21354465;
         5'd6:    v = 32'd10679838;
         5'd7:    v = 32'd5340245;
         5'd8:    v = 32'd2670163;
         5'd9:    v = 32'd1335087;
         5'd10:   v = 32'd667544;
         5'd11:   v = 32'd333772;
         5'd12:   v = 32'd166886;
         5'd13:   v = 32'd83443;
         5'd14:   v = 32'd41722;
         5'd15:   v = 32'd20861;
         5'd16:   v = 32'd10430;
         5'd17:   v = 32'd5215;
         5'd18:   v = 32'd2608;
         5'd19:   v = 32'd1304;
         5'd20:   v = 32'd652;
         5'd21:   v = 32'd326;
         5'd22:   v = 32'd163;
         5'd23:   v = 32'd81;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

   typedef struct packed {
      logic load;
      logic cordic_step;
      logic bin_calc;
      logic mem_read;
      logic update;
      logic clear_write;
      logic sqrt_init;
      logic sqrt_step;
      logic rsp_load;
      logic cfg_write;
   } cmd_type;

   typedef struct packed {
      logic drop;
      logic rsp_busy;
   } sts_type;

endpackage

// ===== sv/ptsb_if.sv =====
// ----------------------------------------------------------------------------
// ptsb_if: channel interfaces of the point to scan binner
// Request, response and register write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ptsb_req_if #(parameter int COORD_BITS = 16, parameter int BIN_BITS = 9);
   logic                  valid;
   logic                  ready;
   logic [1:0]            operation;
   logic [COORD_BITS-1:0] y_mm;
   logic [COORD_BITS-1:0] z_mm;
   logic                  point_invalid;
   logic [BIN_BITS-1:0]   read_bin;
   modport source (output valid, operation, y_mm, z_mm, point_invalid, read_bin,
                   input ready);
   modport sink   (input valid, operation, y_mm, z_mm, point_invalid, read_bin,
                   output ready);
endinterface

interface ptsb_rsp_if #(parameter int BIN_BITS = 9);
   logic                valid;
   logic                ready;
   logic [BIN_BITS-1:0] bin_number;
   logic [15:0]         range_mm;
   modport source (output valid, bin_number, range_mm, input ready);
   modport sink   (input valid, bin_number, range_mm, output ready);
endinterface

interface ptsb_csr_if;
   logic        valid;
   logic        ready;
   logic [14:0] max_range_mm;
   modport source (output valid, max_range_mm, input ready);
   modport sink   (input valid, max_range_mm, output ready);
endinterface

// ===== sv/ptsb_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptsb_ctrl: sequencer of the point to scan binner
// One-hot state machine and step counter driving the datapath.
// ----------------------------------------------------------------------------
module ptsb_ctrl
   import ptsb_pkg::*;
#(
   parameter int BIN_COUNT = 360,
   parameter int BIN_BITS  = 9
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_operation,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  sts_type             sts,
   output cmd_type             cmd,
   output logic [STEP_BITS-1:0] step,
   output logic [BIN_BITS-1:0] clear_addr
);

   localparam int CNT_BITS = (BIN_BITS > STEP_BITS) ? BIN_BITS : STEP_BITS;
   localparam logic [CNT_BITS-1:0] CNT_LAST_BIN = CNT_BITS'(BIN_COUNT - 1);
   localparam logic [CNT_BITS-1:0] CNT_LAST_CORDIC = CNT_BITS'(CORDIC_STEPS - 1);
   localparam logic [CNT_BITS-1:0] CNT_LAST_SQRT = CNT_BITS'(SQRT_STEPS - 1);

   typedef enum logic [9:0] {
      ST_CLEAR   = 10'b00_0000_0001,
      ST_IDLE    = 10'b00_0000_0010,
      ST_CORDIC  = 10'b00_0000_0100,
      ST_BIN     = 10'b00_0000_1000,
      ST_READ    = 10'b00_0001_0000,
      ST_UPDATE  = 10'b00_0010_0000,
      ST_SQRT_RD = 10'b00_0100_0000,
      ST_SQRT_LD = 10'b00_1000_0000,
      ST_SQRT    = 10'b01_0000_0000,
      ST_RESP    = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic accept;

   assign req_ready  = (state_ff == ST_IDLE);
   assign csr_ready  = (state_ff != ST_CLEAR);
   assign accept     = req_valid && req_ready;
   assign step       = count_ff[STEP_BITS-1:0];
   assign clear_addr = count_ff[BIN_BITS-1:0];

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      cmd      = '0;
      cmd.cfg_write = csr_valid && csr_ready;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_write = 1'b1;
            if (count_ff == CNT_LAST_BIN) begin
               state_in = ST_IDLE;
               count_in = '0;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            count_in = '0;
            if (accept) begin
               cmd.load = 1'b1;
               case (op_type'(req_operation))
                  OP_ADD:   if (!sts.drop) state_in = ST_CORDIC;
                  OP_READ:  state_in = ST_SQRT_RD;
                  OP_CLEAR: state_in = ST_CLEAR;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_CORDIC: begin
            cmd.cordic_step = 1'b1;
            if (count_ff == CNT_LAST_CORDIC) begin
               state_in = ST_BIN;
               count_in = '0;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         ST_BIN: begin
            cmd.bin_calc = 1'b1;
            state_in = ST_READ;
         end
         ST_READ: begin
            cmd.mem_read = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in = ST_IDLE;
         end
         ST_SQRT_RD: begin
            cmd.mem_read = 1'b1;
            state_in = ST_SQRT_LD;
         end
         ST_SQRT_LD: begin
            cmd.sqrt_init = 1'b1;
            count_in = '0;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (count_ff == CNT_LAST_SQRT) begin
               state_in = ST_RESP;
               count_in = '0;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         ST_RESP: begin
            if (!sts.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            count_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== sv/ptsb_datapath.sv =====
// ----------------------------------------------------------------------------
// ptsb_datapath: arithmetic and bin store of the point to scan binner
// CORDIC angle unit, squared distance, bin memory, square root, output register.
// ----------------------------------------------------------------------------
module ptsb_datapath
   import ptsb_pkg::*;
#(
   parameter int BIN_COUNT  = 360,
   parameter int BIN_BITS   = 9,
   parameter int COORD_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output sts_type               sts,
   input  logic [STEP_BITS-1:0]  step,
   input  logic [BIN_BITS-1:0]   clear_addr,
   input  logic [COORD_BITS-1:0] y_mm,
   input  logic [COORD_BITS-1:0] z_mm,
   input  logic                  point_invalid,
   input  logic [BIN_BITS-1:0]   read_bin,
   input  logic [14:0]           csr_max_range_mm,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [BIN_BITS-1:0]   rsp_bin_number,
   output logic [15:0]           rsp_range_mm
);

   localparam int W        = COORD_BITS + FRAC_SHIFT + 3;
   localparam int SQ_BITS  = 2 * COORD_BITS;
   localparam int SUM_BITS = (SQ_BITS + 1 > 33) ? SQ_BITS + 1 : 33;
   localparam int PROD_BITS = 32 + BIN_BITS + 1;
   localparam logic [BIN_BITS-1:0] LAST_BIN = BIN_BITS'(BIN_COUNT - 1);

   // register and fill value
   logic [14:0] max_range_ff;
   logic [15:0] fill_base;
   logic [31:0] fill_value;

   assign fill_base  = {1'b0, max_range_ff} + FILL_MARGIN;
   assign fill_value = fill_base * fill_base;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_range_ff <= MAX_RANGE_RESET;
      end else if (cmd.cfg_write) begin
         max_range_ff <= csr_max_range_mm;
      end
   end

   // point capture
   logic signed [W-1:0]        cx_ff, cy_ff;
   logic signed [ACC_BITS-1:0] acc_ff;
   logic [SQ_BITS-1:0]         ysq_ff, zsq_ff;
   logic                       yzero_ff, zzero_ff, ypos_ff;
   logic [BIN_BITS-1:0]        addr_ff;
   logic [31:0]                d2_ff;

   logic signed [COORD_BITS-1:0] ys, zs;
   logic signed [SQ_BITS-1:0]    ysq, zsq;

   assign ys  = signed'(y_mm);
   assign zs  = signed'(z_mm);
   assign ysq = ys * ys;
   assign zsq = zs * zs;
   assign sts.drop = point_invalid || zs[COORD_BITS-1];

   // CORDIC step
   logic signed [W-1:0]        dx, dy;
   logic signed [ACC_BITS-1:0] atan_ext;

   assign dx       = cy_ff >>> step;
   assign dy       = cx_ff >>> step;
   assign atan_ext = signed'({2'b00, atan_units(step)});

   // angle to bin
   logic signed [ACC_BITS-1:0] theta_raw;
   logic [31:0]                theta;
   logic [PROD_BITS-1:0]       prod;
   logic [PROD_BITS-32:0]      bin_wide;
   logic [BIN_BITS-1:0]        bin_idx;
   logic [SUM_BITS-1:0]        d2_sum;

   always_comb begin
      theta_raw = signed'({2'b00, HALF_PI_UNITS}) - acc_ff;
      if (yzero_ff) begin
         theta = HALF_PI_UNITS;
      end else if (zzero_ff) begin
         theta = ypos_ff ? 32'd0 : PI_UNITS;
      end else if (theta_raw < 0) begin
         theta = 32'd0;
      end else if (theta_raw > signed'({2'b00, PI_UNITS})) begin
         theta = PI_UNITS;
      end else begin
         theta = theta_raw[31:0];
      end
      prod     = PROD_BITS'(theta) * PROD_BITS'(BIN_COUNT);
      bin_wide = prod[PROD_BITS-1:31];
      if (bin_wide > (PROD_BITS-31)'(BIN_COUNT - 1)) begin
         bin_idx = LAST_BIN;
      end else begin
         bin_idx = bin_wide[BIN_BITS-1:0];
      end
      d2_sum = SUM_BITS'(ysq_ff) + SUM_BITS'(zsq_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cx_ff    <= W'(zs) <<< FRAC_SHIFT;
         cy_ff    <= W'(ys) <<< FRAC_SHIFT;
         acc_ff   <= '0;
         ysq_ff   <= ysq;
         zsq_ff   <= zsq;
         yzero_ff <= (y_mm == '0);
         zzero_ff <= (z_mm == '0);
         ypos_ff  <= !ys[COORD_BITS-1];
         addr_ff  <= (read_bin > LAST_BIN) ? LAST_BIN : read_bin;
      end else if (cmd.cordic_step) begin
         if (!cy_ff[W-1]) begin
            cx_ff  <= cx_ff + dx;
            cy_ff  <= cy_ff - dy;
            acc_ff <= acc_ff + atan_ext;
         end else begin
            cx_ff  <= cx_ff - dx;
            cy_ff  <= cy_ff + dy;
            acc_ff <= acc_ff - atan_ext;
         end
      end else if (cmd.bin_calc) begin
         addr_ff <= bin_idx;
         d2_ff   <= (d2_sum > SUM_BITS'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : d2_sum[31:0];
      end
   end

   // bin memory
   logic [31:0] mem [BIN_COUNT];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.clear_write) begin
         mem[clear_addr] <= fill_value;
      end else if (cmd.update && (rd_data_ff > d2_ff)) begin
         mem[addr_ff] <= d2_ff;
      end
      if (cmd.mem_read) begin
         rd_data_ff <= mem[addr_ff];
      end
   end

   // restoring square root, two bits a step
   logic [31:0] sq_v_ff, sq_res_ff, sq_bit, sq_trial;

   assign sq_bit   = 32'h4000_0000 >> {step, 1'b0};
   assign sq_trial = sq_res_ff + sq_bit;

   always_ff @(posedge clock) begin
      if (cmd.sqrt_init) begin
         sq_v_ff   <= rd_data_ff;
         sq_res_ff <= '0;
      end else if (cmd.sqrt_step) begin
         if (sq_v_ff >= sq_trial) begin
            sq_v_ff   <= sq_v_ff - sq_trial;
            sq_res_ff <= (sq_res_ff >> 1) + sq_bit;
         end else begin
            sq_res_ff <= sq_res_ff >> 1;
         end
      end
   end

   // output register
   logic rsp_valid_ff;

   assign rsp_valid    = rsp_valid_ff;
   assign sts.rsp_busy = rsp_valid_ff && !rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_bin_number <= addr_ff;
         rsp_range_mm   <= sq_res_ff[15:0];
      end
   end

endmodule

// ===== sv/point_to_scan_binner.sv =====
// ----------------------------------------------------------------------------
// point_to_scan_binner: depth points folded into a planar range scan
// Top level joining the sequencer and the datapath to the channels.
// ----------------------------------------------------------------------------
// Usage:
//  req_ch carries one item per command: add point, read bin or clear scan.
//  rsp_ch returns one item per read: bin number and floor sqrt of the bin.
//  csr_ch writes max_range_mm; it is used only when the bins are refilled.
// Sequence:
//  add point  : 24 CORDIC iterations, bin, memory read, write.
//  invalid or behind-the-sensor point, unused op : accepted with no further work.
//  read bin   : memory read, sqrt load, 16 square root steps, output load.
//  clear scan : accept, then one bin a cycle.
//  One item is worked on at a time; a new item is accepted only when idle.
// Reset:
//  a clearing pass fills every bin with 4000 mm squared;
//  req_ch and csr_ch are held not ready until it ends.
// Stall:
//  a finished read waits in the output register while other items are
//  accepted; a further read waits for it to be taken, blocking new items.
// ----------------------------------------------------------------------------
module point_to_scan_binner
   import ptsb_pkg::*;
#(
   parameter int BIN_COUNT  = 360,
   parameter int COORD_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   ptsb_req_if.sink   req_ch,
   ptsb_rsp_if.source rsp_ch,
   ptsb_csr_if.sink   csr_ch
);

   localparam int BIN_BITS = $clog2(BIN_COUNT);

   cmd_type              cmd;
   sts_type              sts;
   logic [STEP_BITS-1:0] step;
   logic [BIN_BITS-1:0]  clear_addr;

   ptsb_ctrl #(
      .BIN_COUNT (BIN_COUNT),
      .BIN_BITS  (BIN_BITS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .req_operation (req_ch.operation),
      .csr_valid     (csr_ch.valid),
      .csr_ready     (csr_ch.ready),
      .sts           (sts),
      .cmd           (cmd),
      .step          (step),
      .clear_addr    (clear_addr)
   );

   ptsb_datapath #(
      .BIN_COUNT  (BIN_COUNT),
      .BIN_BITS   (BIN_BITS),
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .step             (step),
      .clear_addr       (clear_addr),
      .y_mm             (req_ch.y_mm),
      .z_mm             (req_ch.z_mm),
      .point_invalid    (req_ch.point_invalid),
      .read_bin         (req_ch.read_bin),
      .csr_max_range_mm (csr_ch.max_range_mm),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_bin_number   (rsp_ch.bin_number),
      .rsp_range_mm     (rsp_ch.range_mm)
   );

endmodule

// ===== sv/ptsb_checker.sv =====
// ----------------------------------------------------------------------------
// ptsb_checker: port level checks of the point to scan binner
// Output hold, reset clearing pass and bin range, bound to the top level.
// ----------------------------------------------------------------------------
module ptsb_checker #(
   parameter int BIN_COUNT = 360,
   parameter int BIN_BITS  = 9
) (
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                csr_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [BIN_BITS-1:0] rsp_bin_number,
   input logic [15:0]         rsp_range_mm
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bin_number)
                                  && $stable(rsp_range_mm))
      else $error("stalled response item changed");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !req_ready && !csr_ready)
      else $error("channels ready during clearing pass");

   a_clear_blocks_req: assert property (@(posedge clock) disable iff (reset)
      !csr_ready |-> !req_ready)
      else $error("item accepted during clearing pass");

   a_bin_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_bin_number <= BIN_BITS'(BIN_COUNT - 1))
      else $error("reported bin out of range");

endmodule

bind point_to_scan_binner ptsb_checker #(
   .BIN_COUNT (BIN_COUNT),
   .BIN_BITS  (BIN_BITS)
) u_ptsb_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ch.ready),
   .csr_ready      (csr_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_bin_number (rsp_ch.bin_number),
   .rsp_range_mm   (rsp_ch.range_mm)
);

// ===== tb/tb_point_to_scan_binner.sv =====
// ----------------------------------------------------------------------------
// tb_point_to_scan_binner: self-checking bench for the point to scan binner
// Drives add/read/clear items with random gaps, predicts every bin read with
// an own CORDIC/bin/sqrt model and checks each returned item field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_point_to_scan_binner;
   import ptsb_pkg::*;

   localparam int BINS      = 360;
   localparam int LAST_BIN  = BINS - 1;
   localparam int IDLE_WAIT = 400;      // > clear pass, covers trailing work
   localparam int CYCLE_CAP = 1_500_000;

   logic clock;
   logic reset;

   ptsb_req_if #(.COORD_BITS(16), .BIN_BITS(9)) req_ch ();
   ptsb_rsp_if #(.BIN_BITS(9))                  rsp_ch ();
   ptsb_csr_if                                  csr_ch ();

   point_to_scan_binner #(.BIN_COUNT(BINS), .COORD_BITS(16)) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   // one input item
   typedef struct {
      op_type      op;
      logic [15:0] y;
      logic [15:0] z;
      logic        inv;
      logic [8:0]  rbin;
   } scan_cmd_t;

   // a reply waiting to come back
   typedef struct {
      logic [8:0]  bin;
      logic [15:0] range;
   } bin_reply_t;

   // directed row: item plus optional hand-typed range
   typedef struct {
      scan_cmd_t   cmd;
      logic        typed;
      logic [15:0] range;
   } row_t;

   // predictor state
   logic [31:0] scan_sq [BINS];
   logic [14:0] max_range;

   bin_reply_t  pending_replies [$];
   int          fail_count = 0;
   longint      cycle_count = 0;

   // -------------------------------------------------------------------------
   // clock, cycle limit
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_CAP) begin
         $display("FAIL point_to_scan_binner");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // predictor
   // -------------------------------------------------------------------------
   function automatic longint floor_shr(longint v, int s);
      return v >>> s;   // arithmetic shift floors toward minus infinity
   endfunction

   // atan2(z,y) in pi/2^31 units, z >= 0
   function automatic longint scan_theta(longint y, longint z);
      longint cx, cy, acc, dx, dy;
      acc = 0;
      if (y == 0) return longint'(HALF_PI_UNITS);
      if (z == 0) return (y > 0) ? 0 : longint'(PI_UNITS);
      cx = z <<< FRAC_SHIFT;
      cy = y <<< FRAC_SHIFT;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = floor_shr(cy, i);
         dy = floor_shr(cx, i);
         if (cy >= 0) begin
            cx += dx; cy -= dy; acc += longint'(atan_units(i[4:0]));
         end else begin
            cx -= dx; cy += dy; acc -= longint'(atan_units(i[4:0]));
         end
      end
      acc = longint'(HALF_PI_UNITS) - acc;
      if (acc < 0) acc = 0;
      if (acc > longint'(PI_UNITS)) acc = longint'(PI_UNITS);
      return acc;
   endfunction

   function automatic logic [15:0] floor_sqrt(logic [31:0] v);
      logic [31:0] r, b;
      r = 0;
      b = 32'h4000_0000;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r[15:0];
   endfunction

   task automatic refill_scan();
      logic [31:0] f;
      f = (32'(max_range) + 32'd1000) * (32'(max_range) + 32'd1000);
      for (int i = 0; i < BINS; i++) scan_sq[i] = f;
   endtask

   // apply one accepted item, queue the reply of a read
   task automatic predict_scan(scan_cmd_t c);
      longint     y, z, idx, d2;
      bin_reply_t r;
      y = longint'(signed'(c.y));
      z = longint'(signed'(c.z));
      case (c.op)
         OP_ADD: begin
            if (!c.inv && z >= 0) begin
               idx = (scan_theta(y, z) * BINS) >>> 31;
               if (idx > LAST_BIN) idx = LAST_BIN;
               d2 = y * y + z * z;
               if (d2 > 64'hFFFF_FFFF) d2 = 64'hFFFF_FFFF;
               if (longint'(scan_sq[idx]) > d2) scan_sq[idx] = d2[31:0];
            end
         end
         OP_READ: begin
            r.bin   = (c.rbin > LAST_BIN) ? 9'(LAST_BIN) : c.rbin;
            r.range = floor_sqrt(scan_sq[r.bin]);
            pending_replies.push_back(r);
         end
         OP_CLEAR: refill_scan();
         default: ;  // unused code: no effect
      endcase
   endtask

   // -------------------------------------------------------------------------
   // drivers
   // -------------------------------------------------------------------------
   // valid stays high after a handshake so that a zero gap gives back to back
   task automatic send_cmd(scan_cmd_t c);
      int gap;
      gap = $urandom_range(0, 3);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.operation     <= c.op;
      req_ch.y_mm          <= c.y;
      req_ch.z_mm          <= c.z;
      req_ch.point_invalid <= c.inv;
      req_ch.read_bin      <= c.rbin;
      do @(posedge clock); while (!req_ch.ready);
      predict_scan(c);
   endtask

   // drop valid before any wait on the block
   task automatic req_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // registers written only with the block idle
   task automatic wait_idle();
      req_idle();
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (IDLE_WAIT) @(posedge clock);
   endtask

   task automatic write_max_range(logic [14:0] v);
      wait_idle();
      csr_ch.valid        <= 1'b1;
      csr_ch.max_range_mm <= v;
      do @(posedge clock); while (!csr_ch.ready);
      max_range = v;
      csr_ch.valid <= 1'b0;
   endtask

   function automatic scan_cmd_t mk(op_type op, int y, int z, bit inv, int rb);
      scan_cmd_t c;
      c.op = op; c.y = y[15:0]; c.z = z[15:0]; c.inv = inv; c.rbin = rb[8:0];
      return c;
   endfunction

   function automatic scan_cmd_t rand_cmd();
      scan_cmd_t c;
      int        k;
      k      = $urandom_range(0, 99);
      c.y    = 16'($urandom);
      c.z    = 16'($urandom);
      c.inv  = ($urandom_range(0, 15) == 0);
      c.rbin = 9'($urandom_range(0, 511));
      if (k < 55) begin
         c.op = OP_ADD;
         // mostly small, in-window points so bins actually shrink
         if ($urandom_range(0, 3) != 0) begin
            c.y = 16'($signed($urandom_range(0, 8000)) - 4000);
            c.z = 16'($urandom_range(0, 6000));
         end
      end else if (k < 93) begin
         c.op = OP_READ;
         if ($urandom_range(0, 7) != 0) c.rbin = 9'($urandom_range(0, LAST_BIN));
      end else if (k < 97) begin
         c.op = OP_CLEAR;
      end else begin
         c.op = op_type'(2'd3);
      end
      return c;
   endfunction

   // -------------------------------------------------------------------------
   // result checker
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      bin_reply_t e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_replies.size() == 0) begin
            $error("unexpected item: bin %0d range %0d", rsp_ch.bin_number,
                   rsp_ch.range_mm);
            fail_count++;
         end else begin
            e = pending_replies.pop_front();
            if (rsp_ch.bin_number !== e.bin) begin
               $error("bin_number: expected %0d, got %0d", e.bin, rsp_ch.bin_number);
               fail_count++;
            end
            if (rsp_ch.range_mm !== e.range) begin
               $error("range_mm: expected %0d, got %0d", e.range, rsp_ch.range_mm);
               fail_count++;
            end
         end
      end
   end

   // random back-pressure before each item, with calm stretches
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = (cycle_count % 20000 < 3000) ? 0 : $urandom_range(0, 3);
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // -------------------------------------------------------------------------
   // stimulus
   // -------------------------------------------------------------------------
   initial begin
      row_t      rows [$];
      row_t      rw;
      scan_cmd_t c;
      int        guard;

      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.operation    <= OP_ADD;
      req_ch.y_mm         <= '0;
      req_ch.z_mm         <= '0;
      req_ch.point_invalid <= 1'b0;
      req_ch.read_bin     <= '0;
      csr_ch.valid        <= 1'b0;
      csr_ch.max_range_mm <= '0;
      max_range = MAX_RANGE_RESET;
      refill_scan();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed table; typed ranges are hand-typed and checked against the predictor
      rw.typed = 1'b0; rw.range = '0;
      rw.cmd = mk(OP_READ, 0, 0, 0, 0);          rw.typed = 1; rw.range = 4000;
      rows.push_back(rw);
      rw.cmd = mk(OP_READ, 0, 0, 0, 511);        rows.push_back(rw); // clamped
      rw.typed = 0;
      rw.cmd = mk(OP_ADD, 100, 0, 1, 0);         rows.push_back(rw); // invalid
      rw.cmd = mk(OP_READ, 0, 0, 0, 0);          rw.typed = 1; rw.range = 4000;
      rows.push_back(rw);
      rw.typed = 0;
      rw.cmd = mk(OP_ADD, 5, -1, 0, 0);          rows.push_back(rw); // behind
      rw.cmd = mk(OP_ADD, 0, 0, 0, 0);           rows.push_back(rw); // origin
      rw.cmd = mk(OP_READ, 0, 0, 0, 180);        rw.typed = 1; rw.range = 0;
      rows.push_back(rw);
      rw.typed = 0;
      rw.cmd = mk(OP_ADD, 1234, 0, 0, 0);        rows.push_back(rw); // +y axis
      rw.cmd = mk(OP_READ, 0, 0, 0, 0);          rw.typed = 1; rw.range = 1234;
      rows.push_back(rw);
      rw.typed = 0;
      rw.cmd = mk(OP_ADD, -777, 0, 0, 0);        rows.push_back(rw); // -y axis
      rw.cmd = mk(OP_READ, 0, 0, 0, 359);        rw.typed = 1; rw.range = 777;
      rows.push_back(rw);
      rw.typed = 0;
      rw.cmd = mk(OP_ADD, -32768, 32767, 0, 0);  rows.push_back(rw); // wide
      rw.cmd = mk(OP_ADD, 32767, 32767, 0, 0);   rows.push_back(rw);
      rw.cmd = mk(OP_ADD, -32768, 0, 0, 0);      rows.push_back(rw);
      rw.cmd = mk(OP_ADD, 0, 32767, 0, 0);       rows.push_back(rw);
      rw.cmd = mk(OP_ADD, 300, 400, 0, 0);       rows.push_back(rw);
      rw.cmd = mk(OP_ADD, -300, 400, 0, 0);      rows.push_back(rw);
      rw.cmd = mk(OP_READ, 0, 0, 0, 90);         rows.push_back(rw);
      rw.cmd = mk(OP_READ, 0, 0, 0, 270);        rows.push_back(rw);
      rw.cmd = mk(op_type'(2'd3), -1, -1, 1, 511); rows.push_back(rw); // unused
      rw.cmd = mk(OP_CLEAR, 0, 0, 0, 0);         rows.push_back(rw);
      rw.cmd = mk(OP_READ, 0, 0, 0, 180);        rw.typed = 1; rw.range = 4000;
      rows.push_back(rw);

      foreach (rows[i]) begin
         send_cmd(rows[i].cmd);
         if (rows[i].typed && pending_replies[$].range !== rows[i].range) begin
            $error("range_mm: expected %0d, got %0d (predictor)", rows[i].range,
                   pending_replies[$].range);
            fail_count++;
         end
      end

      // settings sweep: extremes, bit patterns, then random, each followed by a clear
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: write_max_range(15'd0);
            1: write_max_range(15'h7FFF);
            2: write_max_range(15'h5555);
            3: write_max_range(15'h2AAA);
            default: write_max_range(15'($urandom));
         endcase
         send_cmd(mk(OP_CLEAR, 0, 0, 0, 0));
         send_cmd(mk(OP_READ, 0, 0, 0, $urandom_range(0, LAST_BIN)));
         for (int n = 0; n < 140; n++) begin
            c = rand_cmd();
            send_cmd(c);
            if (n == 70) begin
               // hold off until every outstanding read is back
               req_idle();
               while (pending_replies.size() != 0) @(posedge clock);
            end
         end
      end

      req_idle();
      guard = 0;
      while (pending_replies.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (60) @(posedge clock);
      if (pending_replies.size() != 0) begin
         $error("%0d read items never returned", pending_replies.size());
         fail_count++;
      end

      if (fail_count == 0) begin
         $display("PASS point_to_scan_binner");
      end else begin
         $display("FAIL point_to_scan_binner");
      end
      $finish;
   end

endmodule
